// ----- src/xrng_pkg.sv -----
// Package for the xoroshiro generator with bounded range draws.
// Holds payload structs, operation codes, constants and the controller/datapath interface.
// Used by every module under src.
package xrng_pkg;

    localparam int unsigned WordW = 64;

    localparam logic [1:0] OP_SEED  = 2'd0;
    localparam logic [1:0] OP_NEXT  = 2'd1;
    localparam logic [1:0] OP_RANGE = 2'd2;

    localparam logic [63:0] GOLDEN_STEP     = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_ONE     = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_TWO     = 64'h94D049BB133111EB;
    localparam logic [63:0] SEED_FALLBACK   = 64'hDEADBEEFCAFEBABE;
    localparam logic [63:0] WORD_A_FALLBACK = 64'h0123456789ABCDEF;
    localparam logic [63:0] WORD_B_FALLBACK = 64'hFEDCBA9876543210;
    localparam int unsigned ROT_A   = 49;
    localparam int unsigned SHIFT_T = 17;
    localparam int unsigned ROT_B   = 28;
    localparam int unsigned RETRY_LIMIT = 64;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] seed_value;
        logic [63:0] timestamp;
        logic [63:0] range_low;
        logic [63:0] range_high;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value;
        logic        is_seeded;
    } t_out_item;

    // datapath operations, one per command pulse
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,      // unused; the load enable latches the item, picks the seed source, computes span
        CMD_MIX_ADD,   // acc += golden, z = acc
        CMD_MIX_X30,   // z ^= z>>30
        CMD_MUL,       // start 64x64 multiply of z by selected constant
        CMD_MIX_X27,
        CMD_MIX_X31_A, // word_a = prod ^ prod>>31 on the second product
        CMD_MIX_X31_B, // word_b = ..., zero fix, seeded
        CMD_DRAW,      // sum and advance
        CMD_DIV_THR,   // start divider on (-span) % span
        CMD_DIV_X,     // start divider on draw % span
        CMD_RES_ZERO,
        CMD_RES_LOW,
        CMD_RES_MASK,
        CMD_RES_MOD,
        CMD_RES_DRAW
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic mul_sel_two;
    } t_ctrl;

    typedef struct packed {
        logic [1:0] operation;
        logic       seeded;
        logic       low_ge_high;
        logic       span_zero;
        logic       span_pow2;
        logic       below_thresh;
        logic       mul_done;
        logic       div_done;
    } t_stat;

endpackage

// ----- src/xoroshiro_rng_with_bounded_range.sv -----
// xoroshiro_rng_with_bounded_range: 128-bit xoroshiro generator, splitmix64 seeding, range draws.
// Sequence: a next item with seeded state draws and then delivers; seeding runs two mix steps
// (each through two partial-product multiplies); a range with non-power-of-two span adds two
// divider runs plus one redraw per rejection retry, and seeds itself first when it must.
// Throughput: one item at a time; the next item is taken after the result is delivered.
// Reset: synchronous active low, clears both state words and the seeded flag.
module xoroshiro_rng_with_bounded_range import xrng_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    t_ctrl w_ctrl;
    t_stat w_stat;
    logic  w_load;

    // controller sequences the item; datapath holds state and arithmetic
    xrng_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_stat(w_stat), .o_ctrl(w_ctrl),
        .o_load_en(w_load)
    );

    xrng_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load_en(w_load), .i_item(i_item),
        .i_ctrl(w_ctrl), .o_stat(w_stat), .o_result(o_item)
    );

`ifndef SYNTHESIS
    // never take a new item while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input ready while result pending");
    // a delivered result always reports seeded after a seed item completes
    a_seed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && w_stat.operation == OP_SEED) |-> o_item.is_seeded)
        else $error("seed result without seeded flag");
    // result holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_item.value))
        else $error("result changed under stall");
`endif
endmodule

// ----- src/xrng_mul.sv -----
// Multi-cycle 64x64 low-half multiplier built from 32x32 partial products.
// Depends on xrng_pkg for the word width.
module xrng_mul import xrng_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WordW-1:0] i_a,
    input  logic [WordW-1:0] i_b,
    output logic [WordW-1:0] o_p,
    output logic             o_done
);
    logic [WordW-1:0] r_a, r_b, r_acc;
    logic [1:0]       r_step;
    logic             r_busy;
    logic [31:0]      w_x, w_y;
    logic [63:0]      w_pp;

    // step 0: lo*lo, step 1: hi*lo, step 2: lo*hi (low halves only needed for cross terms)
    always_comb begin
        case (r_step)
            2'd0:    begin w_x = r_a[31:0];  w_y = r_b[31:0];  end
            2'd1:    begin w_x = r_a[63:32]; w_y = r_b[31:0];  end
            default: begin w_x = r_a[31:0];  w_y = r_b[63:32]; end
        endcase
        w_pp = {32'd0, w_x} * {32'd0, w_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_a <= i_a;
                r_b <= i_b;
                r_acc <= '0;
                r_step <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_step == 2'd0) begin
                    r_acc <= w_pp;
                end else begin
                    r_acc <= r_acc + {w_pp[31:0], 32'd0};
                end
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_step <= r_step + 2'd1;
            end
        end
    end

    assign o_p = r_acc;
endmodule

// ----- src/xrng_div.sv -----
// Restoring radix-2 remainder unit, one quotient bit per cycle.
// Depends on xrng_pkg for the word width.
module xrng_div import xrng_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WordW-1:0] i_num,
    input  logic [WordW-1:0] i_den,
    output logic [WordW-1:0] o_rem,
    output logic             o_done
);
    localparam int unsigned CntW = $clog2(WordW + 1);

    logic [WordW-1:0] r_num, r_den, r_rem;
    logic [CntW-1:0]  r_cnt;
    logic             r_busy;
    logic [WordW:0]   w_shift, w_diff;

    assign w_shift = {r_rem, r_num[WordW-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CntW'(WordW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // hold the partial remainder below the divisor
                r_rem <= w_diff[WordW] ? w_shift[WordW-1:0] : w_diff[WordW-1:0];
                r_num <= {r_num[WordW-2:0], 1'b0};
                r_cnt <= r_cnt - CntW'(1);
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_rem = r_rem;
endmodule

// ----- src/xrng_datapath.sv -----
// Datapath: state words, splitmix accumulator, span logic, multiplier and divider.
// Depends on xrng_pkg, xrng_mul and xrng_div.
module xrng_datapath import xrng_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load_en,
    input  t_in_item  i_item,
    input  t_ctrl     i_ctrl,
    output t_stat     o_stat,
    output t_out_item o_result
);
    logic [63:0] r_a, r_b, r_acc, r_z, r_x, r_thr, r_span, r_lo, r_hi, r_res;
    logic [1:0]  r_op;
    logic        r_seeded;
    logic        r_thr_pending;
    logic [63:0] w_prod, w_rem, w_sum, w_t, w_bx, w_seed, w_mixb;
    logic        w_mul_done, w_div_done, w_mul_start, w_div_start;
    logic [63:0] w_div_num;

    assign w_mul_start = (i_ctrl.cmd == CMD_MUL);
    assign w_div_start = (i_ctrl.cmd == CMD_DIV_THR) || (i_ctrl.cmd == CMD_DIV_X);
    assign w_div_num   = (i_ctrl.cmd == CMD_DIV_THR) ? (64'd0 - r_span) : r_x;

    xrng_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mul_start), .i_a(r_z),
        .i_b(i_ctrl.mul_sel_two ? MIX_MUL_TWO : MIX_MUL_ONE),
        .o_p(w_prod), .o_done(w_mul_done)
    );

    xrng_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start), .i_num(w_div_num),
        .i_den(r_span), .o_rem(w_rem), .o_done(w_div_done)
    );

    assign w_sum  = r_a + r_b;
    assign w_t    = r_b << SHIFT_T;
    assign w_bx   = r_b ^ r_a;
    // final mix stage works on the second product, which the multiplier holds
    assign w_mixb = w_prod ^ (w_prod >> 31);
    // seed source: item seed for a seed op, else timestamp; zero falls back
    always_comb begin
        w_seed = (i_item.operation == OP_SEED) ? i_item.seed_value : i_item.timestamp;
        if (w_seed == 64'd0) w_seed = i_item.timestamp;
        if (w_seed == 64'd0) w_seed = SEED_FALLBACK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
            r_seeded <= 1'b0;
        end else begin
            case (i_ctrl.cmd)
                CMD_MIX_X31_A: r_a <= w_mixb;
                CMD_MIX_X31_B: begin
                    if (r_a == 64'd0 && w_mixb == 64'd0) begin
                        r_a <= WORD_A_FALLBACK;
                        r_b <= WORD_B_FALLBACK;
                    end else begin
                        r_b <= w_mixb;
                    end
                    r_seeded <= 1'b1;
                end
                CMD_DRAW: begin
                    r_a <= ((r_a << ROT_A) | (r_a >> (64 - ROT_A))) ^ w_bx ^ w_t;
                    r_b <= (w_bx << ROT_B) | (w_bx >> (64 - ROT_B));
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_en) begin
            r_op   <= i_item.operation;
            r_lo   <= i_item.range_low;
            r_hi   <= i_item.range_high;
            r_acc  <= w_seed;
            r_span <= i_item.range_high - i_item.range_low + 64'd1;
        end
        case (i_ctrl.cmd)
            CMD_MIX_ADD: begin
                r_acc <= r_acc + GOLDEN_STEP;
                r_z   <= r_acc + GOLDEN_STEP;
            end
            CMD_MIX_X30: r_z <= r_z ^ (r_z >> 30);
            CMD_MIX_X27: r_z <= w_prod ^ (w_prod >> 27);
            CMD_MIX_X31_A: r_z <= r_z;
            CMD_DRAW: r_x <= w_sum;
            CMD_RES_ZERO: r_res <= 64'd0;
            CMD_RES_LOW:  r_res <= r_lo;
            CMD_RES_MASK: r_res <= r_lo + (r_x & (r_span - 64'd1));
            CMD_RES_MOD:  r_res <= r_lo + w_rem;
            CMD_RES_DRAW: r_res <= r_x;
            default: ;
        endcase
        if (w_div_done && i_ctrl.cmd == CMD_NONE && r_thr_pending) r_thr <= w_rem;
    end

    // the first divider run after a range item's start holds the threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_thr_pending <= 1'b0;
        else if (i_ctrl.cmd == CMD_DIV_THR) r_thr_pending <= 1'b1;
        else if (w_div_done) r_thr_pending <= 1'b0;
    end

    assign o_stat.operation    = r_op;
    assign o_stat.seeded       = r_seeded;
    assign o_stat.low_ge_high  = (r_lo >= r_hi);
    assign o_stat.span_zero    = (r_span == 64'd0);
    assign o_stat.span_pow2    = ((r_span & (r_span - 64'd1)) == 64'd0);
    assign o_stat.below_thresh = (r_x < r_thr);
    assign o_stat.mul_done     = w_mul_done;
    assign o_stat.div_done     = w_div_done;
    assign o_result.value      = r_res;
    assign o_result.is_seeded  = r_seeded;
endmodule

// ----- src/xrng_ctrl.sv -----
// Controller state machine: sequences seeding, draws, divider runs and result hand-off.
// Depends on xrng_pkg.
module xrng_ctrl import xrng_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_load_en
);
    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_MADD, S_MX30, S_MUL1, S_MW1, S_MX27, S_MUL2, S_MW2,
        S_MX31, S_DRAW, S_POST, S_THR, S_THRW, S_XDIV, S_XW, S_OUT
    } t_state;

    localparam int unsigned TryW = $clog2(RETRY_LIMIT + 1);

    t_state        r_state;
    logic          r_second, r_range, r_thr_ok, r_ready, r_valid;
    logic [TryW-1:0] r_tries;
    t_ctrl         r_ctrl;

    assign o_ready   = r_ready;
    assign o_valid   = r_valid;
    assign o_ctrl    = r_ctrl;
    assign o_load_en = r_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ready  <= 1'b1;
            r_valid  <= 1'b0;
            r_second <= 1'b0;
            r_range  <= 1'b0;
            r_thr_ok <= 1'b0;
            r_tries  <= '0;
            r_ctrl   <= '{cmd: CMD_NONE, mul_sel_two: 1'b0};
        end else begin
            r_ctrl.cmd <= CMD_NONE;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_ready <= 1'b0;
                    r_state <= S_DECODE;
                end
                S_DECODE: begin
                    r_second <= 1'b0;
                    r_thr_ok <= 1'b0;
                    r_tries  <= '0;
                    r_range  <= (i_stat.operation == OP_RANGE);
                    case (i_stat.operation)
                        OP_SEED: begin r_ctrl.cmd <= CMD_MIX_ADD; r_state <= S_MADD; end
                        OP_NEXT: begin
                            if (i_stat.seeded) begin
                                r_ctrl.cmd <= CMD_DRAW; r_state <= S_DRAW;
                            end else begin
                                r_ctrl.cmd <= CMD_MIX_ADD; r_state <= S_MADD;
                            end
                        end
                        OP_RANGE: begin
                            if (i_stat.low_ge_high || i_stat.span_zero) begin
                                r_ctrl.cmd <= CMD_RES_LOW; r_state <= S_OUT;
                            end else if (!i_stat.span_pow2) begin
                                r_ctrl.cmd <= CMD_DIV_THR; r_state <= S_THRW;
                            end else if (i_stat.seeded) begin
                                r_ctrl.cmd <= CMD_DRAW; r_state <= S_DRAW;
                            end else begin
                                r_ctrl.cmd <= CMD_MIX_ADD; r_state <= S_MADD;
                            end
                        end
                        default: begin r_ctrl.cmd <= CMD_RES_ZERO; r_state <= S_OUT; end
                    endcase
                end
                S_THRW: if (i_stat.div_done) begin
                    r_thr_ok <= 1'b1;
                    if (i_stat.seeded) begin
                        r_ctrl.cmd <= CMD_DRAW; r_state <= S_DRAW;
                    end else begin
                        r_ctrl.cmd <= CMD_MIX_ADD; r_state <= S_MADD;
                    end
                end
                S_MADD: begin r_ctrl.cmd <= CMD_MIX_X30; r_state <= S_MX30; end
                S_MX30: begin
                    r_ctrl.cmd <= CMD_MUL; r_ctrl.mul_sel_two <= 1'b0; r_state <= S_MW1;
                end
                S_MW1: if (i_stat.mul_done) begin
                    r_ctrl.cmd <= CMD_MIX_X27; r_state <= S_MX27;
                end
                S_MX27: begin
                    r_ctrl.cmd <= CMD_MUL; r_ctrl.mul_sel_two <= 1'b1; r_state <= S_MW2;
                end
                S_MW2: if (i_stat.mul_done) begin
                    r_ctrl.cmd <= r_second ? CMD_MIX_X31_B : CMD_MIX_X31_A;
                    r_state <= S_MX31;
                end
                S_MX31: begin
                    if (!r_second) begin
                        r_second <= 1'b1;
                        r_ctrl.cmd <= CMD_MIX_ADD; r_state <= S_MADD;
                    end else if (i_stat.operation == OP_SEED) begin
                        r_ctrl.cmd <= CMD_RES_ZERO; r_state <= S_OUT;
                    end else begin
                        r_ctrl.cmd <= CMD_DRAW; r_state <= S_DRAW;
                    end
                end
                S_DRAW: begin
                    r_tries <= r_tries + TryW'(1);
                    r_state <= S_POST;
                end
                S_POST: begin
                    if (!r_range) begin
                        r_ctrl.cmd <= CMD_RES_DRAW; r_state <= S_OUT;
                    end else if (i_stat.span_pow2) begin
                        r_ctrl.cmd <= CMD_RES_MASK; r_state <= S_OUT;
                    end else if (i_stat.below_thresh && r_tries < TryW'(RETRY_LIMIT)) begin
                        r_ctrl.cmd <= CMD_DRAW; r_state <= S_DRAW;
                    end else begin
                        r_ctrl.cmd <= CMD_DIV_X; r_state <= S_XW;
                    end
                end
                S_XW: if (i_stat.div_done) begin
                    r_ctrl.cmd <= CMD_RES_MOD; r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_valid) begin
                        r_valid <= 1'b1;
                    end else if (i_ready) begin
                        r_valid <= 1'b0;
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic unused_c;
    assign unused_c = r_thr_ok;
endmodule

// ----- verif/xoroshiro_rng_with_bounded_range_tb.sv -----
// Testbench for xoroshiro_rng_with_bounded_range: seed, next and range items checked
// against an in-bench predictor of the generator state. Depends on xrng_pkg.
`timescale 1ns / 1ps
module xoroshiro_rng_with_bounded_range_tb;
    import xrng_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    xoroshiro_rng_with_bounded_range u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_item  (out_item)
    );

    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Predicted generator state
    logic [63:0] gen_a;
    logic [63:0] gen_b;
    logic        gen_seeded;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        fail_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        hold_send;
    bit        stim_done;

    function automatic logic [63:0] splitmix(inout logic [63:0] acc);
        logic [63:0] z;
        acc = acc + GOLDEN_STEP;
        z = acc;
        z = (z ^ (z >> 30)) * MIX_MUL_ONE;
        z = (z ^ (z >> 27)) * MIX_MUL_TWO;
        return z ^ (z >> 31);
    endfunction

    function automatic logic [63:0] rotl64(logic [63:0] x, int k);
        return (x << k) | (x >> (64 - k));
    endfunction

    task automatic seed_state(logic [63:0] seed, logic [63:0] ts);
        logic [63:0] acc;
        if (seed == 0) seed = ts;
        if (seed == 0) seed = SEED_FALLBACK;
        acc = seed;
        gen_a = splitmix(acc);
        gen_b = splitmix(acc);
        if (gen_a == 0 && gen_b == 0) begin
            gen_a = WORD_A_FALLBACK;
            gen_b = WORD_B_FALLBACK;
        end
        gen_seeded = 1'b1;
    endtask

    task automatic draw_word(logic [63:0] ts, output logic [63:0] sum);
        logic [63:0] t;
        if (!gen_seeded) seed_state(ts, ts);
        sum = gen_a + gen_b;
        t = gen_b << SHIFT_T;
        gen_b = gen_b ^ gen_a;
        gen_a = rotl64(gen_a, ROT_A) ^ gen_b ^ t;
        gen_b = rotl64(gen_b, ROT_B);
    endtask

    task automatic draw_in_range(logic [63:0] lo, logic [63:0] hi, logic [63:0] ts,
                                 output logic [63:0] res);
        logic [63:0] span;
        logic [63:0] thresh;
        logic [63:0] x;
        int          tries;
        res = lo;
        span = hi - lo + 64'd1;
        if (lo >= hi || span == 0) return;
        if ((span & (span - 64'd1)) == 0) begin
            draw_word(ts, x);
            res = lo + (x & (span - 64'd1));
            return;
        end
        thresh = (64'd0 - span) % span;
        tries = 0;
        do begin
            draw_word(ts, x);
            tries++;
        end while (x < thresh && tries < RETRY_LIMIT);
        res = lo + x % span;
    endtask

    // Compute the result of one accepted item and advance the predicted state
    task automatic predict_result(t_in_item it);
        t_out_item r;
        logic [63:0] v;
        v = 64'd0;
        case (it.operation)
            OP_SEED:  seed_state(it.seed_value, it.timestamp);
            OP_NEXT:  draw_word(it.timestamp, v);
            OP_RANGE: draw_in_range(it.range_low, it.range_high, it.timestamp, v);
            default:  v = 64'd0;
        endcase
        r.value = v;
        r.is_seeded = gen_seeded;
        expected_results.push_back(r);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Favor small and edge values so masks, rejection and wrap cases all show up
    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            3: return 64'($urandom_range(0, 1000));
            default: return rand64();
        endcase
    endfunction

    function automatic t_in_item make_item(logic [1:0] op, logic [63:0] sd, logic [63:0] ts,
                                          logic [63:0] lo, logic [63:0] hi);
        t_in_item it;
        it.operation = op;
        it.seed_value = sd;
        it.timestamp = ts;
        it.range_low = lo;
        it.range_high = hi;
        return it;
    endfunction

    function automatic t_in_item random_item();
        logic [1:0]  op;
        logic [63:0] lo;
        logic [63:0] hi;
        int          r;
        r = $urandom_range(0, 99);
        op = (r < 8) ? OP_SEED : (r < 45) ? OP_NEXT : (r < 97) ? OP_RANGE : OP_UNUSED;
        lo = pick_word();
        case ($urandom_range(0, 3))
            0: hi = lo + (64'd1 << $urandom_range(0, 63)) - 64'd1;
            1: hi = lo + 64'($urandom_range(1, 5000));
            default: hi = pick_word();
        endcase
        return make_item(op, pick_word(), pick_word(), lo, hi);
    endfunction

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Driver: present the head of the pending queue, hold it until accepted
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            // drop the accepted item; the head is then the next one to send
            if (in_valid && in_ready) pending_items.pop_front();
            if (in_valid && !in_ready) begin
                // hold item until taken
            end else if (pending_items.size() != 0 && !hold_send
                         && $urandom_range(1, 100) > send_idle_pct) begin
                in_valid <= 1'b1;
                in_item  <= pending_items[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Predict at acceptance so the expected queue tracks the block's order
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) predict_result(in_item);
    end

    // Monitor: compare every result with the oldest expectation
    always @(posedge clk) begin
        t_out_item exp_r;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result value=%h seeded=%b", $time,
                             out_item.value, out_item.is_seeded);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.value !== out_item.value) begin
                        $display("%0t: value mismatch expected=%h actual=%h", $time,
                                 exp_r.value, out_item.value);
                        fail_count++;
                    end
                    if (exp_r.is_seeded !== out_item.is_seeded) begin
                        $display("%0t: is_seeded mismatch expected=%b actual=%b", $time,
                                 exp_r.is_seeded, out_item.is_seeded);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) pending_items.push_back(random_item());
        while (pending_items.size() != 0) @(posedge clk);
    endtask

    initial begin
        gen_a = '0;
        gen_b = '0;
        gen_seeded = 1'b0;
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_send = 1'b0;
        stim_done = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: unseeded empty range, unused op, self-seeding draws, zero seeds
        pending_items.push_back(make_item(OP_RANGE, 0, 5, 64'd9, 64'd9));
        pending_items.push_back(make_item(OP_RANGE, 0, 5, '1, 64'd0));
        pending_items.push_back(make_item(OP_RANGE, 0, 5, 64'd0, '1));
        pending_items.push_back(make_item(OP_UNUSED, '1, '1, '1, '1));
        pending_items.push_back(make_item(OP_NEXT, 0, 64'd0, 0, 0));
        pending_items.push_back(make_item(OP_NEXT, '1, '1, '1, '1));
        pending_items.push_back(make_item(OP_SEED, 64'd0, 64'd0, 0, 0));
        pending_items.push_back(make_item(OP_NEXT, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_SEED, 64'd0, 64'h1234, 0, 0));
        pending_items.push_back(make_item(OP_SEED, '1, 0, 0, 0));
        pending_items.push_back(make_item(OP_SEED, 64'h8000000000000000, 0, 0, 0));
        pending_items.push_back(make_item(OP_RANGE, 0, 0, 64'd10, 64'd17));
        pending_items.push_back(make_item(OP_RANGE, 0, 0, 64'd0, 64'h7FFFFFFFFFFFFFFF));
        pending_items.push_back(make_item(OP_RANGE, 0, 0, 64'd3, 64'd9));
        pending_items.push_back(make_item(OP_RANGE, 0, 0, 64'd0, 64'hFFFFFFFFFFFFFFFE));
        pending_items.push_back(make_item(OP_RANGE, 0, 0, 64'd1, '1));
        pending_items.push_back(make_item(OP_RANGE, 0, 0, 64'd0, 64'h8000000000000000));
        pending_items.push_back(make_item(OP_RANGE, 0, 0, 64'd100, 64'd101));
        pending_items.push_back(make_item(OP_UNUSED, 0, 0, 0, 0));
        while (pending_items.size() != 0) @(posedge clk);

        // Pause the sender until every expected result has drained
        hold_send = 1'b1;
        while (expected_results.size() != 0) @(posedge clk);
        hold_send = 1'b0;

        run_phase(0, 0, 340);
        run_phase(51, 0, 330);
        run_phase(0, 51, 330);
        run_phase(33, 33, 330);
        stim_done = 1'b1;
    end

    // Finish once all results are in, plus a tail for stray outputs
    initial begin
        wait (stim_done);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- xoroshiro_rng_with_bounded_range.f -----
src/xrng_pkg.sv
src/xrng_mul.sv
src/xrng_div.sv
src/xrng_datapath.sv
src/xrng_ctrl.sv
src/xoroshiro_rng_with_bounded_range.sv
verif/xoroshiro_rng_with_bounded_range_tb.sv
